// ===== src/tgfs_pkg.sv =====
// Shared types, saturation constants and counter helpers for the flow statistics core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tgfs_pkg;

   localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
   localparam logic [9:0]  SAT10 = 10'd1023;

   typedef struct packed {
      logic [47:0] sent;
      logic [47:0] recv;
      logic [9:0]  degree;
   } node_stat_type;

   typedef struct packed {
      logic [47:0] bytes;
      logic [47:0] duration;
      logic [31:0] records;
   } edge_stat_type;

   function automatic logic [47:0] add48(input logic [47:0] a, input logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? SAT48 : s[47:0];
   endfunction

   function automatic logic [9:0] deg_inc(input logic [9:0] d);
      return (d == SAT10) ? SAT10 : d + 10'd1;
   endfunction

   function automatic logic [31:0] rec_inc(input logic [31:0] r);
      return (r == SAT32) ? SAT32 : r + 32'd1;
   endfunction

endpackage
`default_nettype wire

// ===== src/tgfs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tgfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/traffic_graph_flow_stats_core.sv =====
// Flow statistics core: node and edge tables in RAM, one record at a time.
// Tables are searched linearly through one RAM read port: each node entry searched
// (source, then destination) and each edge entry searched takes a read state and a
// compare state, then read-modify-write and hand-off follow. Next record taken on return to idle.
// Reset clears the node and edge fill counts and the result valid; the tables need
// no clearing since only entries below the fill counts are read. Uses tgfs_pkg, tgfs_ram.
`timescale 1ns / 1ps
`default_nettype none
module traffic_graph_flow_stats_core #(
   parameter int MAX_NODES = 256,
   parameter int MAX_EDGES = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_source_address,
   input  wire logic [31:0] req_destination_address,
   input  wire logic [31:0] req_byte_count,
   input  wire logic [31:0] req_duration_us,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_accepted,
   output logic [7:0]       rsp_source_index,
   output logic [7:0]       rsp_destination_index,
   output logic             rsp_source_was_new,
   output logic             rsp_destination_was_new,
   output logic             rsp_edge_was_new,
   output logic [9:0]       rsp_source_degree_now,
   output logic [9:0]       rsp_destination_degree_now,
   output logic [47:0]      rsp_source_sent_total,
   output logic [47:0]      rsp_destination_received_total,
   output logic [47:0]      rsp_edge_byte_total,
   output logic [31:0]      rsp_edge_record_total
);

   localparam int NIW = $clog2(MAX_NODES);
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int EIW = $clog2(MAX_EDGES);
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int NSW = $bits(tgfs_pkg::node_stat_type);
   localparam int ESW = $bits(tgfs_pkg::edge_stat_type);

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_EDGE_RD, S_EDGE_CMP,
      S_NS_RD, S_NS_WR, S_ND_RD, S_ND_WR, S_ES_RD, S_ES_WR, S_DONE
   } state_type;

   state_type state_ff;

   // captured record
   logic [31:0] sa_ff, da_ff, bc_ff, du_ff;
   // search control
   logic           phase_ff;              // 0 source lookup, 1 destination lookup
   logic [NCW-1:0] nidx_ff, ncnt_ff;
   logic [ECW-1:0] eidx_ff, ecnt_ff;
   logic [NIW-1:0] s_ff, d_ff;
   logic [EIW-1:0] ei_ff;
   logic           snew_ff, dnew_ff, efound_ff, rev_ff, ok_ff;
   // gathered results
   logic [9:0]  sdeg_ff, ddeg_ff;
   logic [47:0] ssent_ff, drecv_ff, ebytes_ff;
   logic [31:0] erecs_ff;
   // result register
   logic        rsp_valid_ff, acc_ff, rs_new_ff, rd_new_ff, re_new_ff;
   logic [7:0]  rs_idx_ff, rd_idx_ff;
   logic [9:0]  rs_deg_ff, rd_deg_ff;
   logic [47:0] rs_sent_ff, rd_recv_ff, re_bytes_ff;
   logic [31:0] re_recs_ff;

   // memory ports
   logic                    na_we, ns_we, ee_we, es_we;
   logic [NIW-1:0]          na_wa, ns_wa, ns_ra;
   logic [EIW-1:0]          ee_wa, es_wa;
   logic [31:0]             na_rd;
   logic [NSW-1:0]          ns_wd, ns_rd;
   logic [2*NIW-1:0]        ee_wd, ee_rd;
   logic [ESW-1:0]          es_wd, es_rd;
   tgfs_pkg::node_stat_type ns_cur, ns_new;
   tgfs_pkg::edge_stat_type es_cur, es_new;
   logic                    deg_up, at_node_end, at_edge_end;
   logic [NIW-1:0]          ee_src, ee_dst;

   assign ns_cur      = tgfs_pkg::node_stat_type'(ns_rd);
   assign es_cur      = tgfs_pkg::edge_stat_type'(es_rd);
   assign deg_up      = !efound_ff && !rev_ff;
   assign at_node_end = (nidx_ff == ncnt_ff);
   assign at_edge_end = (eidx_ff == ecnt_ff);
   assign ee_src      = ee_rd[2*NIW-1:NIW];
   assign ee_dst      = ee_rd[NIW-1:0];

   // memory write data and enables, by state
   always_comb begin
      na_we  = 1'b0;
      ns_we  = 1'b0;
      ee_we  = 1'b0;
      es_we  = 1'b0;
      na_wa  = ncnt_ff[NIW-1:0];
      ns_wa  = ncnt_ff[NIW-1:0];
      ns_new = '0;
      es_new = '0;
      ee_wa  = ecnt_ff[EIW-1:0];
      es_wa  = efound_ff ? ei_ff : ecnt_ff[EIW-1:0];
      ee_wd  = {s_ff, d_ff};
      ns_ra  = (state_ff == S_NS_RD) ? s_ff : d_ff;
      case (state_ff)
         S_SRCH_RD: begin
            // insert the absent address with zeroed counters
            if (at_node_end && ncnt_ff != NCW'(MAX_NODES)) begin
               na_we = 1'b1;
               ns_we = 1'b1;
            end
         end
         S_NS_WR: begin
            ns_new      = ns_cur;
            ns_new.sent = tgfs_pkg::add48(ns_cur.sent, bc_ff);
            if (deg_up) ns_new.degree = tgfs_pkg::deg_inc(ns_cur.degree);
            ns_wa = s_ff;
            ns_we = 1'b1;
         end
         S_ND_WR: begin
            ns_new      = ns_cur;
            ns_new.recv = tgfs_pkg::add48(ns_cur.recv, bc_ff);
            if (deg_up) ns_new.degree = tgfs_pkg::deg_inc(ns_cur.degree);
            ns_wa = d_ff;
            ns_we = 1'b1;
         end
         S_ES_WR: begin
            if (efound_ff) begin
               es_new.bytes    = tgfs_pkg::add48(es_cur.bytes, bc_ff);
               es_new.duration = tgfs_pkg::add48(es_cur.duration, du_ff);
               es_new.records  = tgfs_pkg::rec_inc(es_cur.records);
            end else begin
               es_new.bytes    = {16'd0, bc_ff};
               es_new.duration = {16'd0, du_ff};
               es_new.records  = 32'd1;
               ee_we           = 1'b1;
            end
            es_we = 1'b1;
         end
         default: begin
         end
      endcase
      ns_wd = NSW'(ns_new);
      es_wd = ESW'(es_new);
   end

   tgfs_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_node_addr (
      .clock(clock), .wr_en(na_we), .wr_addr(na_wa), .wr_data(phase_ff ? da_ff : sa_ff),
      .rd_addr(nidx_ff[NIW-1:0]), .rd_data(na_rd));

   tgfs_ram #(.WIDTH(NSW), .DEPTH(MAX_NODES)) u_node_stat (
      .clock(clock), .wr_en(ns_we), .wr_addr(ns_wa), .wr_data(ns_wd),
      .rd_addr(ns_ra), .rd_data(ns_rd));

   tgfs_ram #(.WIDTH(2*NIW), .DEPTH(MAX_EDGES)) u_edge_ends (
      .clock(clock), .wr_en(ee_we), .wr_addr(ee_wa), .wr_data(ee_wd),
      .rd_addr(eidx_ff[EIW-1:0]), .rd_data(ee_rd));

   tgfs_ram #(.WIDTH(ESW), .DEPTH(MAX_EDGES)) u_edge_stat (
      .clock(clock), .wr_en(es_we), .wr_addr(es_wa), .wr_data(es_wd),
      .rd_addr(ei_ff), .rd_data(es_rd));

   // sequencer: search, update, then hand the result to the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ncnt_ff      <= '0;
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the result once taken, unless a new one replaces it
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  sa_ff     <= req_source_address;
                  da_ff     <= req_destination_address;
                  bc_ff     <= req_byte_count;
                  du_ff     <= req_duration_us;
                  phase_ff  <= 1'b0;
                  nidx_ff   <= '0;
                  snew_ff   <= 1'b0;
                  dnew_ff   <= 1'b0;
                  efound_ff <= 1'b0;
                  rev_ff    <= 1'b0;
                  ok_ff     <= 1'b0;
                  state_ff  <= S_SRCH_RD;
               end
            end
            S_SRCH_RD: begin
               if (at_node_end) begin
                  if (ncnt_ff == NCW'(MAX_NODES)) begin
                     state_ff <= S_DONE;          // node table full: fail
                  end else begin
                     ncnt_ff <= ncnt_ff + NCW'(1);
                     if (phase_ff) begin
                        d_ff     <= ncnt_ff[NIW-1:0];
                        dnew_ff  <= 1'b1;
                        eidx_ff  <= '0;
                        state_ff <= S_EDGE_RD;
                     end else begin
                        s_ff     <= ncnt_ff[NIW-1:0];
                        snew_ff  <= 1'b1;
                        phase_ff <= 1'b1;
                        nidx_ff  <= '0;
                     end
                  end
               end else begin
                  state_ff <= S_SRCH_CMP;
               end
            end
            S_SRCH_CMP: begin
               if (na_rd == (phase_ff ? da_ff : sa_ff)) begin
                  if (phase_ff) begin
                     d_ff     <= nidx_ff[NIW-1:0];
                     eidx_ff  <= '0;
                     state_ff <= S_EDGE_RD;
                  end else begin
                     s_ff     <= nidx_ff[NIW-1:0];
                     phase_ff <= 1'b1;
                     nidx_ff  <= '0;
                     state_ff <= S_SRCH_RD;
                  end
               end else begin
                  nidx_ff  <= nidx_ff + NCW'(1);
                  state_ff <= S_SRCH_RD;
               end
            end
            S_EDGE_RD: begin
               if (at_edge_end) begin
                  // no forward edge: the sweep has also settled the reverse one
                  state_ff <= (ecnt_ff == ECW'(MAX_EDGES)) ? S_DONE : S_NS_RD;
               end else begin
                  state_ff <= S_EDGE_CMP;
               end
            end
            S_EDGE_CMP: begin
               if (ee_src == s_ff && ee_dst == d_ff) begin
                  efound_ff <= 1'b1;
                  ei_ff     <= eidx_ff[EIW-1:0];
                  state_ff  <= S_NS_RD;
               end else begin
                  if (ee_src == d_ff && ee_dst == s_ff) rev_ff <= 1'b1;
                  eidx_ff  <= eidx_ff + ECW'(1);
                  state_ff <= S_EDGE_RD;
               end
            end
            S_NS_RD: state_ff <= S_NS_WR;
            S_NS_WR: begin
               sdeg_ff  <= ns_new.degree;
               ssent_ff <= ns_new.sent;
               state_ff <= S_ND_RD;
            end
            S_ND_RD: state_ff <= S_ND_WR;
            S_ND_WR: begin
               ddeg_ff  <= ns_new.degree;
               drecv_ff <= ns_new.recv;
               // self loop: both bumps land on one node
               if (s_ff == d_ff) sdeg_ff <= ns_new.degree;
               state_ff <= efound_ff ? S_ES_RD : S_ES_WR;
            end
            S_ES_RD: state_ff <= S_ES_WR;
            S_ES_WR: begin
               ebytes_ff <= es_new.bytes;
               erecs_ff  <= es_new.records;
               ok_ff     <= 1'b1;
               if (!efound_ff) ecnt_ff <= ecnt_ff + ECW'(1);
               state_ff  <= S_DONE;
            end
            S_DONE: begin
               // hold until the output register is free or being emptied
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  acc_ff       <= ok_ff;
                  rs_idx_ff    <= ok_ff ? 8'(s_ff) : 8'd0;
                  rd_idx_ff    <= ok_ff ? 8'(d_ff) : 8'd0;
                  rs_new_ff    <= ok_ff & snew_ff;
                  rd_new_ff    <= ok_ff & dnew_ff;
                  re_new_ff    <= ok_ff & !efound_ff;
                  rs_deg_ff    <= ok_ff ? sdeg_ff : 10'd0;
                  rd_deg_ff    <= ok_ff ? ddeg_ff : 10'd0;
                  rs_sent_ff   <= ok_ff ? ssent_ff : 48'd0;
                  rd_recv_ff   <= ok_ff ? drecv_ff : 48'd0;
                  re_bytes_ff  <= ok_ff ? ebytes_ff : 48'd0;
                  re_recs_ff   <= ok_ff ? erecs_ff : 32'd0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall                      = (state_ff != S_IDLE);
   assign rsp_valid                      = rsp_valid_ff;
   assign rsp_accepted                   = acc_ff;
   assign rsp_source_index               = rs_idx_ff;
   assign rsp_destination_index          = rd_idx_ff;
   assign rsp_source_was_new             = rs_new_ff;
   assign rsp_destination_was_new        = rd_new_ff;
   assign rsp_edge_was_new               = re_new_ff;
   assign rsp_source_degree_now          = rs_deg_ff;
   assign rsp_destination_degree_now     = rd_deg_ff;
   assign rsp_source_sent_total          = rs_sent_ff;
   assign rsp_destination_received_total = rd_recv_ff;
   assign rsp_edge_byte_total            = re_bytes_ff;
   assign rsp_edge_record_total          = re_recs_ff;

endmodule
`default_nettype wire

// ===== tb/tb_flow_stats_checker.sv =====
// Watcher for the flow statistics core: tracks its node and edge tables, predicts each
// result item and compares it with what the core returns. Uses tgfs_pkg for constants.
`timescale 1ns / 1ps
module tb_flow_stats_checker #(
   parameter int NODE_SLOTS = 256,
   parameter int EDGE_SLOTS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [31:0] req_source_address,
   input  wire logic [31:0] req_destination_address,
   input  wire logic [31:0] req_byte_count,
   input  wire logic [31:0] req_duration_us,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_accepted,
   input  wire logic [7:0]  rsp_source_index,
   input  wire logic [7:0]  rsp_destination_index,
   input  wire logic        rsp_source_was_new,
   input  wire logic        rsp_destination_was_new,
   input  wire logic        rsp_edge_was_new,
   input  wire logic [9:0]  rsp_source_degree_now,
   input  wire logic [9:0]  rsp_destination_degree_now,
   input  wire logic [47:0] rsp_source_sent_total,
   input  wire logic [47:0] rsp_destination_received_total,
   input  wire logic [47:0] rsp_edge_byte_total,
   input  wire logic [31:0] rsp_edge_record_total,
   output int               fail_count,
   output int               pending,
   output int               counted_records,
   output int               refused_records
);

   typedef struct packed {
      logic        accepted;
      logic [7:0]  src_idx;
      logic [7:0]  dst_idx;
      logic        src_new;
      logic        dst_new;
      logic        edge_new;
      logic [9:0]  src_deg;
      logic [9:0]  dst_deg;
      logic [47:0] src_sent;
      logic [47:0] dst_recv;
      logic [47:0] edge_bytes;
      logic [31:0] edge_recs;
   } flow_result_type;

   flow_result_type expected_results[$];

   int          slot_of_addr[logic [31:0]];
   int          edge_of_pair[logic [31:0]];
   logic [47:0] sent_tot[NODE_SLOTS];
   logic [47:0] recv_tot[NODE_SLOTS];
   logic [9:0]  degree[NODE_SLOTS];
   logic [47:0] e_bytes[EDGE_SLOTS];
   logic [47:0] e_dur[EDGE_SLOTS];
   logic [31:0] e_recs[EDGE_SLOTS];
   int          nodes_used;
   int          edges_used;

   function automatic logic [47:0] sat_sum(input logic [47:0] a, input logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + 49'(b);
      return s[48] ? tgfs_pkg::SAT48 : s[47:0];
   endfunction

   // find or insert one address; -1 when the node table is full
   function automatic int node_slot(input logic [31:0] addr, output logic created);
      int k;
      created = 1'b0;
      if (slot_of_addr.exists(addr)) return slot_of_addr[addr];
      if (nodes_used >= NODE_SLOTS) return -1;
      k = nodes_used;
      slot_of_addr[addr] = k;
      sent_tot[k] = '0;
      recv_tot[k] = '0;
      degree[k]   = '0;
      nodes_used++;
      created = 1'b1;
      return k;
   endfunction

   function automatic flow_result_type account_record(input logic [31:0] sa,
                                                      input logic [31:0] da,
                                                      input logic [31:0] nb,
                                                      input logic [31:0] du);
      flow_result_type r;
      logic sn, dn;
      int s, d, e;
      logic [31:0] key, rkey;
      r = '0;
      s = node_slot(sa, sn);
      if (s < 0) return r;
      d = node_slot(da, dn);
      if (d < 0) return r;
      key  = {s[15:0], d[15:0]};
      rkey = {d[15:0], s[15:0]};
      e = edge_of_pair.exists(key) ? edge_of_pair[key] : -1;
      if (e < 0 && edges_used >= EDGE_SLOTS) return r;
      sent_tot[s] = sat_sum(sent_tot[s], nb);
      recv_tot[d] = sat_sum(recv_tot[d], nb);
      if (e >= 0) begin
         e_bytes[e] = sat_sum(e_bytes[e], nb);
         e_dur[e]   = sat_sum(e_dur[e], du);
         if (e_recs[e] != tgfs_pkg::SAT32) e_recs[e] = e_recs[e] + 32'd1;
      end else begin
         // degree counts undirected neighbours: skip when the reverse edge exists
         if (!edge_of_pair.exists(rkey)) begin
            if (degree[s] != tgfs_pkg::SAT10) degree[s] = degree[s] + 10'd1;
            if (degree[d] != tgfs_pkg::SAT10) degree[d] = degree[d] + 10'd1;
         end
         e = edges_used;
         edge_of_pair[key] = e;
         e_bytes[e] = 48'(nb);
         e_dur[e]   = 48'(du);
         e_recs[e]  = 32'd1;
         edges_used++;
         r.edge_new = 1'b1;
      end
      r.accepted   = 1'b1;
      r.src_idx    = s[7:0];
      r.dst_idx    = d[7:0];
      r.src_new    = sn;
      r.dst_new    = dn;
      r.src_deg    = degree[s];
      r.dst_deg    = degree[d];
      r.src_sent   = sent_tot[s];
      r.dst_recv   = recv_tot[d];
      r.edge_bytes = e_bytes[e];
      r.edge_recs  = e_recs[e];
      return r;
   endfunction

   flow_result_type got, want;

   always_comb begin
      got = {rsp_accepted, rsp_source_index, rsp_destination_index, rsp_source_was_new,
             rsp_destination_was_new, rsp_edge_was_new, rsp_source_degree_now,
             rsp_destination_degree_now, rsp_source_sent_total,
             rsp_destination_received_total, rsp_edge_byte_total, rsp_edge_record_total};
   end

   assign pending = expected_results.size();

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         slot_of_addr.delete();
         edge_of_pair.delete();
         nodes_used      = 0;
         edges_used      = 0;
         fail_count      = 0;
         counted_records = 0;
         refused_records = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result item: %p", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch\n  expected %p\n  actual   %p", want, got);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = account_record(req_source_address, req_destination_address,
                                  req_byte_count, req_duration_us);
            if (want.accepted) counted_records++;
            else refused_records++;
            expected_results.push_back(want);
         end
      end
   end
endmodule

// ===== tb/tb_traffic_graph_flow_stats_core.sv =====
// Top of the flow statistics core testbench: clock, reset, record stimulus, result stall
// and verdict. Depends on traffic_graph_flow_stats_core and tb_flow_stats_checker.
`timescale 1ns / 1ps
module tb_traffic_graph_flow_stats_core;
   localparam int WATCHDOG_LIMIT = 40000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_source_address = '0;
   logic [31:0] req_destination_address = '0;
   logic [31:0] req_byte_count = '0;
   logic [31:0] req_duration_us = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_accepted;
   logic [7:0]  rsp_source_index;
   logic [7:0]  rsp_destination_index;
   logic        rsp_source_was_new;
   logic        rsp_destination_was_new;
   logic        rsp_edge_was_new;
   logic [9:0]  rsp_source_degree_now;
   logic [9:0]  rsp_destination_degree_now;
   logic [47:0] rsp_source_sent_total;
   logic [47:0] rsp_destination_received_total;
   logic [47:0] rsp_edge_byte_total;
   logic [31:0] rsp_edge_record_total;

   int fail_count, pending, counted_records, refused_records;
   int idle_cycles = 0;
   logic [31:0] addr_pool[$];

   always #5 clock = ~clock;

   traffic_graph_flow_stats_core i_dut (.*);

   tb_flow_stats_checker i_checker (.*);

   // Result-side stall: alternate calm stretches with random short and rare long holds.
   int stall_left = 0;
   int stretch = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stretch <= stretch + 1;
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
         end else if ((stretch / 3000) % 4 != 0 && $urandom_range(0, 3) == 0) begin
            stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80)
                                                       : $urandom_range(1, 3);
         end
         rsp_stall <= (stall_left > 0) ||
                      ((stretch / 3000) % 4 != 0 && $urandom_range(0, 3) == 0);
      end
   end

   // Watchdog: count cycles with no item moving on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Present one record and hold it until the core takes it, then idle for a random gap, which may be zero.
   task automatic send_record(input logic [31:0] sa, input logic [31:0] da,
                              input logic [31:0] nb, input logic [31:0] du);
      int gap;
      req_valid               <= 1'b1;
      req_source_address      <= sa;
      req_destination_address <= da;
      req_byte_count          <= nb;
      req_duration_us         <= du;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7: gap = 0;
         18:                     gap = $urandom_range(20, 70);
         default:                gap = $urandom_range(1, 4);
      endcase
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_bytes();
      case ($urandom_range(0, 7))
         0:       return 32'hFFFF_FFFF;
         1:       return 32'd0;
         2, 3:    return $urandom_range(0, 1500);
         default: return $urandom;
      endcase
   endfunction

   // Draw an address: usually a known one, sometimes a fresh one added to the pool.
   function automatic logic [31:0] pick_addr(input int fresh_pct);
      logic [31:0] a;
      if (addr_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
         a = $urandom;
         addr_pool.push_back(a);
         return a;
      end
      return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, self loops, reverse edges, repeated edges.
      send_record(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_record(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_record(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
      send_record(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_record(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
      send_record(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      send_record(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      send_record(32'hAAAA_AAAA, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
      send_record(32'hC0A8_0001, 32'hAAAA_AAAA, 32'd64, 32'd1000);
      send_record(32'hC0A8_0001, 32'hC0A8_0001, 32'd1500, 32'd20);
      send_record(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      addr_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                    32'hC0A8_0001};

      // Dense traffic over a small graph: repeated edges and growing totals.
      for (int k = 0; k < 800; k++)
         send_record(pick_addr(addr_pool.size() < 24 ? 40 : 0), pick_addr(0),
                     pick_bytes(), $urandom);

      // Sparse traffic with many fresh addresses: drive the node table and then the
      // edge table to full, so refusals of both kinds follow.
      for (int k = 0; k < 1050; k++)
         send_record(pick_addr(30), pick_addr(30), pick_bytes(), $urandom);

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (4000) @(posedge clock);

      $display("covered %0d counted and %0d refused records, nodes and edges up to full",
               counted_records, refused_records);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d failures", fail_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
